// File: src/shkr_pkg.sv
package shkr_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 22;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 22'h3FFFFF;
	localparam logic [2:0]         CMP_COST  = 3'd1;
	localparam logic [2:0]         SWAP_COST = 3'd3;

	localparam logic [1:0] WSEL_INPUT = 2'd0;
	localparam logic [1:0] WSEL_STEP  = 2'd1;
	localparam logic [1:0] WSEL_CARRY = 2'd2;

	typedef struct packed {
		logic       mem_we;
		logic [1:0] wsel;
		logic       carry_load;
		logic       step;
		logic       fwd;
		logic       op_clear;
		logic       out_load;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic swap;
		logic out_valid;
	} status_t;

endpackage

// File: src/shaker_sort_with_op_count.sv
// sort: after the transfer flagged last_in, the list is sorted in backward and forward passes,
// one compare-exchange per cycle in the single element memory, plus per-pass check and setup
// throughput: one value per input cycle while loading; a result loads once the last is taken
// reset: arst_n clears the controller, the counters and the output valid at once
// the element memory is not cleared; reads beyond the current list are never used
module shaker_sort_with_op_count
	import shkr_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [DATA_W-1:0]  value_in,
	input  logic                      last_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  sorted_value,
	output logic                      last_out,
	output logic [COUNT_W-1:0]        work_count
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	cmd_t             cmd;
	status_t          status;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;

	shkr_ctrl #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.IDX_W        (IDX_W),
		.CNT_W        (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_in  (last_in),
		.in_stall (in_stall),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.status   (status)
	);

	shkr_dp #(
		.IDX_W (IDX_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value_in     (value_in),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr),
		.status       (status),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.work_count   (work_count)
	);

endmodule

// File: src/shkr_dp.sv
module shkr_dp
	import shkr_pkg::*;
#(
	parameter int IDX_W = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [DATA_W-1:0]  value_in,
	input  cmd_t                      cmd,
	input  logic [IDX_W-1:0]          rd_addr,
	input  logic [IDX_W-1:0]          wr_addr,
	output status_t                   status,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic signed [DATA_W-1:0]  sorted_value,
	output logic                      last_out,
	output logic [COUNT_W-1:0]        work_count
);

	localparam int DEPTH = 2 ** IDX_W;

	logic signed [DATA_W-1:0] mem_q [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] carry_q;
	logic signed [DATA_W-1:0] wdata;
	logic [COUNT_W-1:0]       op_q;
	logic [COUNT_W+1:0]       op_sum;
	logic                     swap;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     last_q;
	logic [COUNT_W-1:0]       count_q;

	assign swap = cmd.fwd ? (rdata_q < carry_q) : (carry_q < rdata_q);

	always_comb begin
		case (cmd.wsel)
			WSEL_INPUT: wdata = value_in;
			WSEL_STEP:  wdata = swap ? rdata_q : carry_q;
			WSEL_CARRY: wdata = carry_q;
			default:    wdata = carry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[wr_addr] <= wdata;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.carry_load) begin
			carry_q <= rdata_q;
		end else if (cmd.step) begin
			carry_q <= swap ? carry_q : rdata_q;
		end
	end

	assign op_sum = {2'b00, op_q} + (swap ? (COUNT_W+2)'(CMP_COST + SWAP_COST)
		: (COUNT_W+2)'(CMP_COST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
		end else if (cmd.op_clear) begin
			op_q <= '0;
		end else if (cmd.step) begin
			op_q <= (op_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : op_sum[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q <= rdata_q;
			last_q  <= cmd.out_last;
			count_q <= op_q;
		end
	end

	assign status.swap      = swap;
	assign status.out_valid = out_valid_q;

	assign out_valid    = out_valid_q;
	assign sorted_value = value_q;
	assign last_out     = last_q;
	assign work_count   = count_q;

endmodule

// File: src/shkr_ctrl.sv
module shkr_ctrl
	import shkr_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64,
	parameter int IDX_W        = 6,
	parameter int CNT_W        = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_in,
	output logic             in_stall,
	output cmd_t             cmd,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] wr_addr,
	input  status_t          status
);

	localparam logic [3:0] S_LOAD = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_BCHK = 4'd2;
	localparam logic [3:0] S_BLD  = 4'd3;
	localparam logic [3:0] S_BCMP = 4'd4;
	localparam logic [3:0] S_BEND = 4'd5;
	localparam logic [3:0] S_FCHK = 4'd6;
	localparam logic [3:0] S_FLD  = 4'd7;
	localparam logic [3:0] S_FCMP = 4'd8;
	localparam logic [3:0] S_FEND = 4'd9;
	localparam logic [3:0] S_ORD  = 4'd10;
	localparam logic [3:0] S_OWR  = 4'd11;

	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] TWO = CNT_W'(2);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ELEMENTS);

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic [CNT_W-1:0] right_q, right_d;
	logic [CNT_W-1:0] lsp_q, lsp_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic [CNT_W-1:0] rd_pos;
	logic [CNT_W-1:0] wr_pos;

	assign rd_addr = rd_pos[IDX_W-1:0];
	assign wr_addr = wr_pos[IDX_W-1:0];

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		left_d   = left_q;
		right_d  = right_q;
		lsp_d    = lsp_q;
		j_d      = j_q;
		rd_pos   = j_q;
		wr_pos   = j_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_LOAD: begin
				in_stall = 1'b0;
				wr_pos   = fill_q;
				cmd.wsel = WSEL_INPUT;
				if (in_valid) begin
					if (fill_q < CAP) begin
						cmd.mem_we = 1'b1;
						fill_d     = fill_q + ONE;
					end
					if (last_in) begin
						state_d = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.op_clear = 1'b1;
				left_d       = '0;
				right_d      = fill_q - ONE;
				lsp_d        = fill_q;
				state_d      = S_BCHK;
			end
			S_BCHK: begin
				if (right_q > left_q) begin
					rd_pos  = right_q;
					j_d     = right_q;
					state_d = S_BLD;
				end else begin
					left_d  = lsp_q;
					state_d = S_FCHK;
				end
			end
			S_BLD: begin
				cmd.carry_load = 1'b1;
				rd_pos         = j_q - ONE;
				state_d        = S_BCMP;
			end
			S_BCMP: begin
				cmd.step   = 1'b1;
				cmd.mem_we = 1'b1;
				cmd.wsel   = WSEL_STEP;
				wr_pos     = j_q;
				rd_pos     = j_q - TWO;
				j_d        = j_q - ONE;
				if (status.swap) begin
					lsp_d = j_q;
				end
				if (j_q - ONE == left_q) begin
					state_d = S_BEND;
				end
			end
			S_BEND: begin
				cmd.mem_we = 1'b1;
				cmd.wsel   = WSEL_CARRY;
				wr_pos     = left_q;
				left_d     = lsp_q;
				state_d    = S_FCHK;
			end
			S_FCHK: begin
				if (left_q < right_q) begin
					rd_pos  = left_q;
					j_d     = left_q;
					state_d = S_FLD;
				end else begin
					right_d = lsp_q;
					j_d     = '0;
					state_d = (left_q < lsp_q) ? S_BCHK : S_ORD;
				end
			end
			S_FLD: begin
				cmd.carry_load = 1'b1;
				rd_pos         = j_q + ONE;
				state_d        = S_FCMP;
			end
			S_FCMP: begin
				cmd.step   = 1'b1;
				cmd.fwd    = 1'b1;
				cmd.mem_we = 1'b1;
				cmd.wsel   = WSEL_STEP;
				wr_pos     = j_q;
				rd_pos     = j_q + TWO;
				j_d        = j_q + ONE;
				if (status.swap) begin
					lsp_d = j_q;
				end
				if (j_q + ONE == right_q) begin
					state_d = S_FEND;
				end
			end
			S_FEND: begin
				cmd.mem_we = 1'b1;
				cmd.wsel   = WSEL_CARRY;
				wr_pos     = right_q;
				right_d    = lsp_q;
				j_d        = '0;
				state_d    = (left_q < lsp_q) ? S_BCHK : S_ORD;
			end
			S_ORD: begin
				rd_pos = j_q;
				if (!status.out_valid) begin
					state_d = S_OWR;
				end
			end
			S_OWR: begin
				cmd.out_load = 1'b1;
				cmd.out_last = (j_q + ONE == fill_q);
				if (j_q + ONE == fill_q) begin
					fill_d  = '0;
					state_d = S_LOAD;
				end else begin
					j_d     = j_q + ONE;
					state_d = S_ORD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			fill_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
			lsp_q   <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			left_q  <= left_d;
			right_q <= right_d;
			lsp_q   <= lsp_d;
			j_q     <= j_d;
		end
	end

endmodule

// File: src/shkr_checker.sv
module shkr_checker
	import shkr_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [DATA_W-1:0]  sorted_value,
	input logic                      last_out,
	input logic [COUNT_W-1:0]        work_count
);

	logic                     mid_q;
	logic signed [DATA_W-1:0] prev_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic                     out_xfer;

	assign out_xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (out_xfer) begin
			mid_q <= !last_out;
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			prev_q <= sorted_value;
			cnt_q  <= work_count;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value)
			&& $stable(last_out) && $stable(work_count))
		else $error("stalled result changed");

	// no new list is taken while a list is still being emitted
	a_no_load_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |-> in_stall)
		else $error("input taken in the middle of a result list");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_q |-> sorted_value >= prev_q)
		else $error("results out of order");

	a_count_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_q |-> work_count == cnt_q)
		else $error("count changed within a list");

endmodule

bind shaker_sort_with_op_count shkr_checker u_shkr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sorted_value (sorted_value),
	.last_out     (last_out),
	.work_count   (work_count)
);
